// ----- rtl/core/planar_pixel_rmw_engine_unit_assert.svh -----
// assertion macros for the planar pixel engine checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef PLANAR_PIXEL_RMW_ENGINE_UNIT_ASSERT_SVH
`define PLANAR_PIXEL_RMW_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define PPRE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppre port check failed");

// next-cycle implication
`define PPRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppre port check failed");

`endif

// ----- rtl/core/ppre_pkg.sv -----
// shared types and constants of the planar pixel engine
// no dependencies
`timescale 1ns / 1ps

package ppre_pkg;

  localparam int MaxLineWords = 32;
  localparam int MaxLines     = 256;
  localparam int StoreDepth   = MaxLineWords * MaxLines;
  localparam int AddrW        = $clog2(StoreDepth);
  localparam int PlaneCnt     = 4;
  localparam int GroupPix     = 16;
  localparam int GroupShift   = 4;
  localparam int CalcW        = 16;

  localparam logic [5:0] LineWordsRst   = 6'd20;
  localparam logic [8:0] ImageHeightRst = 9'd200;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FILL  = 2'd2
  } ppre_cmd_e;

  typedef enum logic [1:0] {
    REG_LINE_WORDS   = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_CLIP_ENABLE  = 2'd2,
    REG_MASK_ENABLE  = 2'd3
  } ppre_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_GET_RD,
    ST_GET_DATA,
    ST_FILL_INIT,
    ST_FILL_RD,
    ST_FILL_WR
  } ppre_state_e;

  typedef struct packed {
    logic [5:0] line_words;
    logic [8:0] image_height;
    logic       clip_enable;
    logic       mask_enable;
  } ppre_cfg_t;

  typedef struct packed {
    logic load;
    logic fill_init;
    logic mem_rd;
    logic mem_wr;
    logic fill_step;
    logic res_mem;
    logic res_clip;
  } ppre_ctrl_t;

  typedef struct packed {
    logic drop;
    logic fill_empty;
    logic fill_last;
  } ppre_stat_t;

endpackage

// ----- rtl/core/planar_pixel_rmw_engine_unit.sv -----
// top level of the planar pixel engine: config bank, sequencer, datapath
// depends on ppre_pkg, ppre_cfg, ppre_ctrl, ppre_dp
//
// channel   | signals                                   | flow
// command   | start_i busy_o cmd_i pos_* rect_* pen_*   | beat when start_i and !busy_o
// result    | result_valid_o read_color_o read_masked_o | one-cycle strobe, no backpressure
// config    | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | beat when valid and ready
//
// write: busy for store read, store write; a dropped write ends after the read state
// read: store read, data state, strobe registered from it; clipped: read state, likewise
// fill: init state, then one read-modify-write per pixel inside the image
// the single-port plane and mask stores set this sequence; stores hold no reset
// result strobe cannot be stalled; config beats are always taken
`timescale 1ns / 1ps

module planar_pixel_rmw_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [10:0] pos_x_i,
  input  logic signed [9:0]  pos_y_i,
  input  logic [9:0]         rect_width_i,
  input  logic [8:0]         rect_height_i,
  input  logic [3:0]         pen_color_i,
  input  logic               pen_masked_i,
  output logic               result_valid_o,
  output logic [3:0]         read_color_o,
  output logic               read_masked_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i
);
  import ppre_pkg::*;

  ppre_cfg_t  cfg;
  ppre_ctrl_t ctrl;
  ppre_stat_t stat;

  ppre_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppre_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl),
    .stat_i  (stat)
  );

  ppre_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .pen_color_i    (pen_color_i),
    .pen_masked_i   (pen_masked_i),
    .result_valid_o (result_valid_o),
    .read_color_o   (read_color_o),
    .read_masked_o  (read_masked_o)
  );

endmodule

// ----- rtl/core/ppre_cfg.sv -----
// configuration register bank of the planar pixel engine
// depends on ppre_pkg
`timescale 1ns / 1ps

module ppre_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  output ppre_pkg::ppre_cfg_t cfg_o
);
  import ppre_pkg::*;

  ppre_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LINE_WORDS:   cfg_d.line_words   = cfg_data_i[5:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i;
        REG_CLIP_ENABLE:  cfg_d.clip_enable  = cfg_data_i[0];
        REG_MASK_ENABLE:  cfg_d.mask_enable  = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_words   <= LineWordsRst;
      cfg_q.image_height <= ImageHeightRst;
      cfg_q.clip_enable  <= 1'b1;
      cfg_q.mask_enable  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/ppre_ctrl.sv -----
// command sequencer of the planar pixel engine
// depends on ppre_pkg
`timescale 1ns / 1ps

module ppre_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          cmd_i,
  output logic                busy_o,
  output ppre_pkg::ppre_ctrl_t ctrl_o,
  input  ppre_pkg::ppre_stat_t stat_i
);
  import ppre_pkg::*;

  ppre_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i)
            CMD_WRITE: state_d = ST_PIX_RD;
            CMD_READ:  state_d = ST_GET_RD;
            CMD_FILL:  state_d = ST_FILL_INIT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD:    state_d = stat_i.drop ? ST_IDLE : ST_PIX_WR;
      ST_PIX_WR:    state_d = ST_IDLE;
      ST_GET_RD:    state_d = stat_i.drop ? ST_IDLE : ST_GET_DATA;
      ST_GET_DATA:  state_d = ST_IDLE;
      ST_FILL_INIT: state_d = stat_i.fill_empty ? ST_IDLE : ST_FILL_RD;
      ST_FILL_RD:   state_d = ST_FILL_WR;
      ST_FILL_WR:   state_d = stat_i.fill_last ? ST_IDLE : ST_FILL_RD;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = start_i;
      end
      ST_PIX_RD:    ctrl_o.mem_rd = !stat_i.drop;
      ST_PIX_WR:    ctrl_o.mem_wr = 1'b1;
      ST_GET_RD: begin
        ctrl_o.mem_rd   = !stat_i.drop;
        ctrl_o.res_clip = stat_i.drop;
      end
      ST_GET_DATA:  ctrl_o.res_mem = 1'b1;
      ST_FILL_INIT: ctrl_o.fill_init = 1'b1;
      ST_FILL_RD:   ctrl_o.mem_rd = 1'b1;
      ST_FILL_WR: begin
        ctrl_o.mem_wr    = 1'b1;
        ctrl_o.fill_step = 1'b1;
      end
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/ppre_dp.sv -----
// datapath of the planar pixel engine: coordinates, address, stores, merge
// depends on ppre_pkg
`timescale 1ns / 1ps

module ppre_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppre_pkg::ppre_cfg_t  cfg_i,
  input  ppre_pkg::ppre_ctrl_t ctrl_i,
  output ppre_pkg::ppre_stat_t stat_o,
  input  logic signed [10:0]  pos_x_i,
  input  logic signed [9:0]   pos_y_i,
  input  logic [9:0]          rect_width_i,
  input  logic [8:0]          rect_height_i,
  input  logic [3:0]          pen_color_i,
  input  logic                pen_masked_i,
  output logic                result_valid_o,
  output logic [3:0]          read_color_o,
  output logic                read_masked_o
);
  import ppre_pkg::*;

  logic [PlaneCnt*GroupPix-1:0] plane_mem [StoreDepth];
  logic [GroupPix-1:0]          mask_mem  [StoreDepth];

  logic signed [10:0] cur_x_q;
  logic signed [9:0]  cur_y_q;
  logic [9:0]         rw_q;
  logic [8:0]         rh_q;
  logic [3:0]         color_q;
  logic               masked_q;
  logic [10:0]        fx0_q;
  logic signed [CalcW-1:0] fx1_q;
  logic signed [CalcW-1:0] fy1_q;

  logic [PlaneCnt*GroupPix-1:0] plane_rd_q;
  logic [GroupPix-1:0]          mask_rd_q;

  logic       res_valid_q;
  logic [3:0] res_color_q;
  logic       res_masked_q;

  logic [CalcW-1:0] eff_words, eff_lines, wmax, prod, addr_sum;
  logic [AddrW-1:0] addr;
  logic             in_img;

  logic signed [CalcW-1:0] x_ext, y_ext, x0_s, y0_s, x1_s, y1_s, x1_c, y1_c;
  logic signed [CalcW-1:0] wmax_s, hmax_s, x_inc, y_inc;

  logic [3:0]                   bit_idx;
  logic [GroupPix-1:0]          bit_sel;
  logic [PlaneCnt*GroupPix-1:0] plane_wr;
  logic [GroupPix-1:0]          mask_wr;
  logic [3:0]                   rd_color;
  logic                         rd_masked;

  // image size, saturated to the store limits
  assign eff_words = (CalcW'(cfg_i.line_words) > CalcW'(MaxLineWords)) ?
                     CalcW'(MaxLineWords) : CalcW'(cfg_i.line_words);
  assign eff_lines = (CalcW'(cfg_i.image_height) > CalcW'(MaxLines)) ?
                     CalcW'(MaxLines) : CalcW'(cfg_i.image_height);
  assign wmax      = eff_words << GroupShift;

  // word address from the raw coordinate patterns
  assign prod     = CalcW'(unsigned'(cur_y_q)) * eff_words;
  assign addr_sum = prod + CalcW'(cur_x_q[10:GroupShift]);
  assign addr     = addr_sum[AddrW-1:0];

  assign in_img = !cur_x_q[10] && !cur_y_q[9] &&
                  (CalcW'(unsigned'(cur_x_q)) < wmax) &&
                  (CalcW'(unsigned'(cur_y_q)) < eff_lines);

  // fill rectangle bounds
  assign x_ext  = CalcW'(cur_x_q);
  assign y_ext  = CalcW'(cur_y_q);
  assign wmax_s = signed'(wmax);
  assign hmax_s = signed'(eff_lines);
  assign x0_s   = cur_x_q[10] ? '0 : x_ext;
  assign y0_s   = cur_y_q[9] ? '0 : y_ext;
  assign x1_s   = x_ext + signed'(CalcW'(rw_q));
  assign y1_s   = y_ext + signed'(CalcW'(rh_q));
  assign x1_c   = (x1_s > wmax_s) ? wmax_s : x1_s;
  assign y1_c   = (y1_s > hmax_s) ? hmax_s : y1_s;
  assign x_inc  = signed'(CalcW'(unsigned'(cur_x_q))) + CalcW'(1);
  assign y_inc  = signed'(CalcW'(unsigned'(cur_y_q))) + CalcW'(1);

  assign stat_o.drop       = cfg_i.clip_enable && !in_img;
  assign stat_o.fill_empty = (x0_s >= x1_c) || (y0_s >= y1_c);
  assign stat_o.fill_last  = (x_inc == fx1_q) && (y_inc == fy1_q);

  // pixel merge and pixel extract
  assign bit_idx = cur_x_q[3:0];
  assign bit_sel = {1'b1, {(GroupPix-1){1'b0}}} >> bit_idx;

  always_comb begin
    plane_wr  = plane_rd_q;
    rd_color  = '0;
    for (int p = 0; p < PlaneCnt; p++) begin
      if (color_q[p]) begin
        plane_wr[p*GroupPix +: GroupPix] = plane_rd_q[p*GroupPix +: GroupPix] | bit_sel;
      end else begin
        plane_wr[p*GroupPix +: GroupPix] = plane_rd_q[p*GroupPix +: GroupPix] & ~bit_sel;
      end
      rd_color[p] = |(plane_rd_q[p*GroupPix +: GroupPix] & bit_sel);
    end
    mask_wr   = masked_q ? (mask_rd_q & ~bit_sel) : (mask_rd_q | bit_sel);
    rd_masked = cfg_i.mask_enable && !(|(mask_rd_q & bit_sel));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_rd) begin
      plane_rd_q <= plane_mem[addr];
      mask_rd_q  <= mask_mem[addr];
    end
    if (ctrl_i.mem_wr) begin
      plane_mem[addr] <= plane_wr;
    end
    if (ctrl_i.mem_wr && cfg_i.mask_enable) begin
      mask_mem[addr] <= mask_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cur_x_q  <= pos_x_i;
      cur_y_q  <= pos_y_i;
      rw_q     <= rect_width_i;
      rh_q     <= rect_height_i;
      color_q  <= pen_color_i;
      masked_q <= pen_masked_i;
    end else if (ctrl_i.fill_init) begin
      cur_x_q <= 11'(x0_s);
      cur_y_q <= 10'(y0_s);
      fx0_q   <= 11'(x0_s);
      fx1_q   <= x1_c;
      fy1_q   <= y1_c;
    end else if (ctrl_i.fill_step) begin
      if (x_inc == fx1_q) begin
        cur_x_q <= fx0_q;
        cur_y_q <= cur_y_q + 10'sd1;
      end else begin
        cur_x_q <= cur_x_q + 11'sd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_mem) begin
      res_color_q  <= rd_masked ? 4'd0 : rd_color;
      res_masked_q <= rd_masked;
    end else if (ctrl_i.res_clip) begin
      res_color_q  <= 4'd0;
      res_masked_q <= cfg_i.mask_enable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl_i.res_mem || ctrl_i.res_clip;
    end
  end

  assign result_valid_o = res_valid_q;
  assign read_color_o   = res_color_q;
  assign read_masked_o  = res_masked_q;

endmodule

// ----- rtl/core/ppre_checker.sv -----
// port-level checks of the planar pixel engine, bound to the top level
// depends on ppre_pkg and planar_pixel_rmw_engine_unit_assert.svh
`timescale 1ns / 1ps
`include "planar_pixel_rmw_engine_unit_assert.svh"

module ppre_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] cmd_i,
  input logic       result_valid_o
);
  import ppre_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  `PPRE_ASSERT_NEXT(a_result_single, result_valid_o, !result_valid_o)
  `PPRE_ASSERT_IMPL(a_result_when_idle, result_valid_o, !busy_o)
  `PPRE_ASSERT_NEXT(a_no_result_nonread, accept && (cmd_i != CMD_READ), !result_valid_o)
  `PPRE_ASSERT_IMPL(a_read_progress, accept && (cmd_i == CMD_READ), ##2 (result_valid_o || busy_o))

endmodule

bind planar_pixel_rmw_engine_unit ppre_checker u_ppre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o)
);
